/* sv/hsfc_pkg.sv */
// Package with the binary32/binary16 format constants and the conversion functions.
package hsfc_pkg;

	// Request selector codes
	typedef enum logic {
		FUNC_S2H = 1'b0,
		FUNC_H2S = 1'b1
	} func_t;

	localparam logic [7:0]  SGL_EXP_MAX     = 8'hFF;
	localparam logic [7:0]  SGL_EXP_UFLOW   = 8'd102;  // below: flush to signed zero
	localparam logic [7:0]  SGL_EXP_SUBN    = 8'd112;  // at or below: half subnormal
	localparam logic [7:0]  SGL_EXP_OFLOW   = 8'd143;  // at or above: inf or NaN
	localparam logic [7:0]  SUBN_SHIFT_BASE = 8'd113;  // shift = base - exponent
	localparam logic [7:0]  BIAS_DIFF       = 8'd112;  // 127 - 15
	localparam logic [7:0]  SUBN_EXP_BASE   = 8'd103;  // single exponent for lead bit 0
	localparam logic [30:0] SGL_INF_MAG     = 31'h7F800000;
	localparam logic [14:0] HALF_QNAN       = 15'h7E00;
	localparam logic [14:0] HALF_INF        = 15'h7C00;
	localparam logic [4:0]  HALF_EXP_MAX    = 5'd31;

	// Convert a binary32 pattern to binary16 (zero-extended to 32 bits)
	function automatic logic [31:0] f32_to_f16(input logic [31:0] f);
		logic        sgn;
		logic [7:0]  ef;
		logic [9:0]  m;
		logic [10:0] subn;
		logic [7:0]  sh;
		logic        inc;
		logic [14:0] body;
		logic [4:0]  e5;
		sgn  = f[31];
		ef   = f[30:23];
		m    = f[22:13];
		sh   = SUBN_SHIFT_BASE - ef;
		subn = {1'b1, m} >> sh[3:0];
		inc  = f[12] & ((f[11:0] != 12'd0) | m[0]);
		e5   = ef[4:0] - BIAS_DIFF[4:0];
		if (f[30:0] == 31'd0 || ef < SGL_EXP_UFLOW) begin
			body = 15'd0;
		end else if (ef <= SGL_EXP_SUBN) begin
			body = {4'd0, subn};
		end else if (ef >= SGL_EXP_OFLOW) begin
			if (f[30:0] > SGL_INF_MAG) begin
				body = HALF_QNAN | {8'd0, m[9:3]};
			end else begin
				body = HALF_INF;
			end
		end else begin
			// round to nearest even; a mantissa carry walks into the exponent
			body = {e5, m} + {14'd0, inc};
		end
		return {16'd0, sgn, body};
	endfunction

	// Convert a binary16 pattern to binary32
	function automatic logic [31:0] f16_to_f32(input logic [15:0] h);
		logic       sgn;
		logic [4:0] e;
		logic [9:0] m;
		logic [3:0] p;
		logic [3:0] sh;
		logic [9:0] mn;
		logic [7:0] es;
		logic [31:0] r;
		sgn = h[15];
		e   = h[14:10];
		m   = h[9:0];
		p   = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (m[i]) begin
				p = 4'(i);
			end
		end
		sh = 4'd10 - p;
		mn = m << sh;
		es = SUBN_EXP_BASE + {4'd0, p};
		if (e == 5'd0) begin
			if (m == 10'd0) begin
				r = {sgn, 31'd0};
			end else begin
				r = {sgn, es, mn, 13'd0};
			end
		end else if (e == HALF_EXP_MAX) begin
			r = {sgn, SGL_EXP_MAX, m, 13'd0};
		end else begin
			r = {sgn, {3'd0, e} + BIAS_DIFF, m, 13'd0};
		end
		return r;
	endfunction

endpackage

/* sv/half_single_format_converter_top.sv */
// Half/single format converter: input register, conversion logic, result register.
//
// Usage:
//   Raise start with func, single_bits and half_bits for one cycle per request.
//   func 0 converts the binary32 in single_bits to binary16 (low 16 bits of
//   result_bits, upper bits zero); func 1 converts half_bits to binary32.
//   busy is always low, so a request is taken on every cycle start is high.
// Throughput:
//   One request per cycle. The input register holds the request, and the
//   conversion logic between it and the result register is combinational;
//   done and result_bits are driven from the result register stage. done
//   marks result_bits for exactly one cycle.
// Receiver:
//   The receiver cannot stall; each result must be taken in its done cycle.
// Reset:
//   arst_n low clears both valid flags, dropping any request in flight.
//   The payload and result registers are not reset.
module half_single_format_converter_top
	import hsfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        func,
	input  logic [31:0] single_bits,
	input  logic [15:0] half_bits,
	output logic        done,
	output logic [31:0] result_bits
);

	logic        valid_s1;
	func_t       func_s1;
	logic [31:0] single_s1;
	logic [15:0] half_s1;
	logic [31:0] conv;
	logic        done_q;
	logic [31:0] result_q;

	assign busy = 1'b0;

	// Hold the request valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
			done_q   <= valid_s1;
		end
	end

	// Capture the request payload
	always_ff @(posedge clk) begin
		if (start & ~busy) begin
			func_s1   <= func_t'(func);
			single_s1 <= single_bits;
			half_s1   <= half_bits;
		end
	end

	// Convert in the selected direction
	always_comb begin
		case (func_s1)
			FUNC_S2H: conv = f32_to_f16(single_s1);
			FUNC_H2S: conv = f16_to_f32(half_s1);
			default:  conv = 32'd0;
		endcase
	end

	// Register the result
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q <= conv;
		end
	end

	assign done        = done_q;
	assign result_bits = result_q;

	// A request leads to a result through the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##2 done)
		else $error("request did not produce a result after two cycles");

	// A result is only shown for a request held in the input stage
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1))
		else $error("result strobe without a request");

	// A half result keeps the upper 16 bits clear
	a_half_upper: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && func_s1 == FUNC_S2H) |=> (result_bits[31:16] == 16'd0))
		else $error("half result has upper bits set");

	// The block never refuses a request
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

endmodule
